/* sv/idft_pkg.sv */
// shared constants, types and twiddle table for the inverse dft unit
package idft_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int DEF_MAX_POINTS  = 64;
   localparam int CFG_BITS        = 3;
   localparam int LOG2_RESET      = 6;
   localparam int ROM_BITS        = 6;
   localparam int TWID_BITS       = 16;
   localparam int TWID_FRAC       = 15;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [TWID_BITS-1:0]   twiddle_type;

   // quarter wave of the cosine, 17 points
   function automatic twiddle_type quarter_cos(input logic [4:0] i);
      twiddle_type q;
      case (i)
         5'd0:    q = 16'sd32767;
         5'd1:    q = 16'sd32610;
         5'd2:    q = 16'sd32138;
         5'd3:    q = 16'sd31357;
         5'd4:    q = 16'sd30274;
         5'd5:    q = 16'sd28899;
         5'd6:    q = 16'sd27246;
         5'd7:    q = 16'sd25330;
         5'd8:    q = 16'sd23170;
         5'd9:    q = 16'sd20788;
         5'd10:   q = 16'sd18205;
         5'd11:   q = 16'sd15447;
         5'd12:   q = 16'sd12540;
         5'd13:   q = 16'sd9512;
         5'd14:   q = 16'sd6393;
         5'd15:   q = 16'sd3212;
         default: q = 16'sd0;
      endcase
      return q;
   endfunction

   // full-wave cosine of angle 2*pi*i/64
   function automatic twiddle_type rom_cos(input logic [ROM_BITS-1:0] i);
      twiddle_type r;
      logic [ROM_BITS:0] iw;
      iw = {1'b0, i};
      if (iw <= 7'd16) begin
         r = quarter_cos(5'(iw));
      end else if (iw <= 7'd32) begin
         r = -quarter_cos(5'(7'd32 - iw));
      end else if (iw <= 7'd48) begin
         r = -quarter_cos(5'(iw - 7'd32));
      end else begin
         r = quarter_cos(5'(7'd64 - iw));
      end
      return r;
   endfunction

   // sine is the cosine a quarter turn earlier
   function automatic twiddle_type rom_sin(input logic [ROM_BITS-1:0] i);
      return rom_cos(i - ROM_BITS'(16));
   endfunction

endpackage

/* sv/idft_req_if.sv */
// frequency sample channel of the inverse dft unit
interface idft_req_if;
   import idft_pkg::*;

   logic       valid;
   logic       ready;
   sample_type freq_re;
   sample_type freq_im;

   modport source (output valid, output freq_re, output freq_im, input ready);
   modport sink   (input valid, input freq_re, input freq_im, output ready);
endinterface

/* sv/idft_rsp_if.sv */
// time sample channel of the inverse dft unit
interface idft_rsp_if;
   import idft_pkg::*;

   logic       valid;
   logic       ready;
   sample_type time_re;
   sample_type time_im;
   logic       last_out;

   modport source (output valid, output time_re, output time_im, output last_out, input ready);
   modport sink   (input valid, input time_re, input time_im, input last_out, output ready);
endinterface

/* sv/inverse_dft_direct_unit.sv */
// inverse dft unit: direct transform with one shared complex multiply-accumulate
// The unit takes N = 2^log2_points complex Q1.15 frequency samples, one per cycle,
// then produces N complex time samples x[k] = (1/N) sum X[n] exp(+j2pi kn/N),
// rounded half up and saturated, with last_out on the final one. Each time sample
// sums N products from the single complex multiplier (one store read and one
// twiddle lookup per cycle), drains its pipeline (operand registers, product
// registers, accumulator), then is rounded into the output register once that
// is free. A frame thus costs N*N complex multiplies. The input is not ready
// while a frame is being transformed. Writing log2_points (1 to 6, values out of
// range are clamped) discards a partly loaded frame.
module inverse_dft_direct_unit #(
   parameter int MAX_POINTS = idft_pkg::DEF_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [idft_pkg::CFG_BITS-1:0] csr_wr_data,
   idft_req_if.sink                      req_chan,
   idft_rsp_if.source                    rsp_chan
);
   import idft_pkg::*;

   localparam int MAX_LOG2 = $clog2(MAX_POINTS + 1) - 1;
   localparam int DEPTH    = 1 << MAX_LOG2;
   localparam int ADDR_W   = MAX_LOG2;
   localparam int PROD_W   = SAMPLE_BITS + TWID_BITS;
   localparam int ACC_W    = PROD_W + 2 + MAX_LOG2;
   localparam int RESET_L  = (LOG2_RESET > MAX_LOG2) ? MAX_LOG2 : LOG2_RESET;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [1:0] {
      S_LOAD,
      S_ISSUE,
      S_DRAIN,
      S_FINISH
   } state_type;

   function automatic sample_type scale_sat(input logic signed [ACC_W-1:0] a,
                                            input logic [CFG_BITS-1:0] lg);
      logic signed [ACC_W-1:0] rnd;
      logic signed [ACC_W-1:0] shf;
      rnd = a + (ACC_W'(1) << (5'(lg) + 5'd14));
      shf = rnd >>> (5'(lg) + 5'(TWID_FRAC));
      if (shf > SAT_HI) begin
         shf = SAT_HI;
      end else if (shf < SAT_LO) begin
         shf = SAT_LO;
      end
      return SAMPLE_BITS'(shf);
   endfunction

   logic [2*SAMPLE_BITS-1:0] mem [DEPTH];

   state_type               state_ff, state_in;
   logic [CFG_BITS-1:0]     lg_ff, lg_in;
   logic [ADDR_W-1:0]       load_cnt_ff, load_cnt_in;
   logic [ADDR_W-1:0]       k_ff, k_in;
   logic [ADDR_W-1:0]       n_ff, n_in;
   logic [ROM_BITS-1:0]     step_ff, step_in;
   logic [ROM_BITS-1:0]     phase_ff, phase_in;
   logic                    v1_ff, v1_in;
   logic                    v2_ff, v2_in;
   logic [2*SAMPLE_BITS-1:0] rd_data_ff;
   twiddle_type             cos_ff, cos_in;
   twiddle_type             sin_ff, sin_in;
   logic signed [PROD_W-1:0] p_rc_ff, p_rc_in;
   logic signed [PROD_W-1:0] p_is_ff, p_is_in;
   logic signed [PROD_W-1:0] p_rs_ff, p_rs_in;
   logic signed [PROD_W-1:0] p_ic_ff, p_ic_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0] acc_im_ff, acc_im_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sample_type              rsp_re_ff, rsp_re_in;
   sample_type              rsp_im_ff, rsp_im_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    wr_en;
   logic                    out_free;
   logic [ADDR_W-1:0]       last_idx;
   sample_type              xr, xi;
   logic [CFG_BITS-1:0]     lg_clamp;

   assign last_idx = ADDR_W'((7'd1 << lg_ff) - 7'd1);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign xr       = sample_type'(rd_data_ff[SAMPLE_BITS-1:0]);
   assign xi       = sample_type'(rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]);

   always_comb begin
      if (csr_wr_data == '0) begin
         lg_clamp = CFG_BITS'(1);
      end else if (csr_wr_data > CFG_BITS'(MAX_LOG2)) begin
         lg_clamp = CFG_BITS'(MAX_LOG2);
      end else begin
         lg_clamp = csr_wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lg_in        = lg_ff;
      load_cnt_in  = load_cnt_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;

      v1_in   = (state_ff == S_ISSUE);
      v2_in   = v1_ff;
      cos_in  = rom_cos(phase_ff);
      sin_in  = rom_sin(phase_ff);
      p_rc_in = xr * cos_ff;
      p_is_in = xi * sin_ff;
      p_rs_in = xr * sin_ff;
      p_ic_in = xi * cos_ff;

      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (v2_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(p_rc_ff) - ACC_W'(p_is_ff);
         acc_im_in = acc_im_ff + ACC_W'(p_rs_ff) + ACC_W'(p_ic_ff);
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_chan.valid) begin
               wr_en = 1'b1;
               if (load_cnt_ff == last_idx) begin
                  load_cnt_in = '0;
                  k_in        = '0;
                  n_in        = '0;
                  step_in     = '0;
                  phase_in    = '0;
                  acc_re_in   = '0;
                  acc_im_in   = '0;
                  state_in    = S_ISSUE;
               end else begin
                  load_cnt_in = load_cnt_ff + ADDR_W'(1);
               end
            end
         end
         S_ISSUE: begin
            n_in     = n_ff + ADDR_W'(1);
            phase_in = phase_ff + step_ff;
            if (n_ff == last_idx) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_re_in    = scale_sat(acc_re_ff, lg_ff);
               rsp_im_in    = scale_sat(acc_im_ff, lg_ff);
               rsp_last_in  = (k_ff == last_idx);
               acc_re_in    = '0;
               acc_im_in    = '0;
               if (k_ff == last_idx) begin
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + ADDR_W'(1);
                  step_in  = step_ff + ROM_BITS'(7'd1 << (3'd6 - lg_ff));
                  n_in     = '0;
                  phase_in = '0;
                  state_in = S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (csr_wr_en) begin
         lg_in       = lg_clamp;
         load_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[load_cnt_ff] <= {req_chan.freq_im, req_chan.freq_re};
      end
      if (state_ff == S_ISSUE) begin
         rd_data_ff <= mem[n_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         lg_ff        <= CFG_BITS'(RESET_L);
         load_cnt_ff  <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
         step_ff      <= '0;
         phase_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lg_ff        <= lg_in;
         load_cnt_ff  <= load_cnt_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      p_rc_ff     <= p_rc_in;
      p_is_ff     <= p_is_in;
      p_rs_ff     <= p_rs_in;
      p_ic_ff     <= p_ic_in;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_chan.ready    = (state_ff == S_LOAD);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.time_re  = rsp_re_ff;
   assign rsp_chan.time_im  = rsp_im_ff;
   assign rsp_chan.last_out = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (!v1_ff && !v2_ff))
      else $error("mac pipeline busy while loading");

   a_count_outside_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> (load_cnt_ff == '0))
      else $error("load count nonzero during transform");

   a_acc_in_run: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (state_ff == S_ISSUE || state_ff == S_DRAIN))
      else $error("accumulate outside of a transform pass");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (!v1_ff && !v2_ff && $past(state_ff) != S_ISSUE))
      else $error("result taken before the pipeline drained");
`endif

endmodule
